[hw/rtl/tcoc_pkg.sv]
package tcoc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_EYE_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_Z        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CULL_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PARALLEL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INSIDE_MASK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE_MASK = 3'd6;

    localparam logic [1:0] FUNC_CULL  = 2'd0;
    localparam logic [1:0] FUNC_CODES = 2'd1;
    localparam logic [1:0] FUNC_TEST  = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    localparam logic [1:0] CULL_NONE = 2'd0;
    localparam logic [1:0] CULL_ONE  = 2'd1;
    localparam logic [1:0] CULL_TWO  = 2'd2;

    localparam int ST_VISIBLE  = 0;
    localparam int ST_REVERSED = 1;
    localparam int ST_CLIPPED  = 2;

    localparam logic [1:0] SIDE_FRONT = 2'b01;
    localparam logic [1:0] SIDE_BACK  = 2'b10;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]         func;
        logic [11:0]        face_index;
        logic [9:0]         vertex_a;
        logic [9:0]         vertex_b;
        logic [9:0]         vertex_c;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] plane_offset;
        logic [15:0]        vertex_outcodes;
    } in_word_t;

    typedef struct packed {
        logic        face_visible;
        logic        face_reversed;
        logic        face_clipped;
        logic [15:0] clip_codes;
        logic        any_clipped;
        logic [15:0] vertex_refcount;
        logic [1:0]  vertex_sides;
    } out_word_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] face_index;
        logic [9:0]  vertex_a;
        logic [9:0]  vertex_b;
        logic [9:0]  vertex_c;
        logic [15:0] vertex_outcodes;
        logic        hide;
        logic        reversed;
        logic        mark_sides;
    } cmd_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_VCODE,
        BK_VCODE_RES,
        BK_FACE_RD,
        BK_FACE_CHK,
        BK_CODE_RD,
        BK_CODE_ACC,
        BK_DECIDE,
        BK_CNT_RD,
        BK_CNT_WR,
        BK_STATUS_WR,
        BK_DONE
    } bk_state_t;

endpackage

[hw/rtl/tcoc_ram.sv]
module tcoc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/tcoc_front.sv]
module tcoc_front
    import tcoc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_word_t           in_word,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    input  logic [1:0]         cull_mode,
    input  logic               parallel_projection,
    input  back_status_t       status,
    input  logic               q_ready,
    output logic               q_push,
    output cmd_t               q_cmd
);

    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic signed [63:0] p0_reg;
    logic signed [63:0] p1_reg;
    logic signed [63:0] p2_reg;
    logic signed [31:0] ref1_reg;
    logic signed [31:0] ref2_reg;
    cmd_t               cmd1_reg;
    cmd_t               cmd2_reg;
    logic signed [65:0] sum_reg;
    logic signed [65:0] sum_next;
    logic signed [65:0] ref_ext;
    logic               adv;
    logic               accept;
    logic               back;
    logic               culling;
    logic               hide;

    assign adv      = !s2_valid_reg || q_ready;
    assign in_stall = !adv || status.init_busy;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // products of the dot product
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p0_reg   <= 64'(in_word.normal_x) * 64'(eye_x);
            p1_reg   <= 64'(in_word.normal_y) * 64'(eye_y);
            p2_reg   <= 64'(in_word.normal_z) * 64'(eye_z);
            ref1_reg <= parallel_projection ? 32'sd0 : in_word.plane_offset;
            cmd1_reg <= '{func: in_word.func, face_index: in_word.face_index,
                          vertex_a: in_word.vertex_a, vertex_b: in_word.vertex_b,
                          vertex_c: in_word.vertex_c,
                          vertex_outcodes: in_word.vertex_outcodes,
                          hide: 1'b0, reversed: 1'b0, mark_sides: 1'b0};
        end
    end

    assign sum_next = {{2{p0_reg[63]}}, p0_reg} + {{2{p1_reg[63]}}, p1_reg}
                    + {{2{p2_reg[63]}}, p2_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg  <= sum_next;
            ref2_reg <= ref1_reg;
            cmd2_reg <= cmd1_reg;
        end
    end

    // exact dot below reference
    assign ref_ext = {{18{ref2_reg[31]}}, ref2_reg, 16'b0};
    assign back    = culling && (sum_reg < ref_ext);
    assign culling = (cull_mode == CULL_ONE) || (cull_mode == CULL_TWO);
    assign hide    = (cull_mode == CULL_ONE) && back;

    always_comb
    begin
        q_push           = s2_valid_reg && q_ready;
        q_cmd            = cmd2_reg;
        q_cmd.hide       = hide;
        q_cmd.reversed   = back && !hide;
        q_cmd.mark_sides = (cull_mode == CULL_TWO);
    end

endmodule

[hw/rtl/tcoc_queue.sv]
module tcoc_queue
    import tcoc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic ready,
    input  logic pop,
    output logic valid,
    output cmd_t head
);

    cmd_t       slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign ready = (count_reg != 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

[hw/rtl/tcoc_back.sv]
module tcoc_back
    import tcoc_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_FACES = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  cmd_t         q_cmd,
    output logic         q_pop,
    input  logic [15:0]  inside_mask,
    input  logic [15:0]  outside_mask,
    output back_status_t status,
    output logic         out_valid,
    input  logic         out_stall,
    output out_word_t    out_word
);

    localparam int VA_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int FA_W = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int MAXD = (MAX_VERTICES > MAX_FACES) ? MAX_VERTICES : MAX_FACES;
    localparam int CL_W = $clog2(MAXD + 1);

    bk_state_t        state_reg;
    bk_state_t        state_next;
    cmd_t             cmd_reg;
    logic [1:0]       k_reg;
    logic [15:0]      comb_reg;
    logic [2:0]       st_reg;
    logic [CL_W-1:0]  clr_reg;
    logic             clr_item_reg;
    logic             seen_reg;
    logic             r_vis_reg;
    logic             r_rev_reg;
    logic             r_clp_reg;
    logic [15:0]      r_codes_reg;
    logic [15:0]      r_cnt_reg;
    logic [1:0]       r_sides_reg;
    logic             out_valid_reg;
    out_word_t        out_word_reg;

    logic [9:0]       v_sel;
    logic [16:0]      v_ext;
    logic [16:0]      f_ext;
    logic             v_ok;
    logic             f_ok;
    logic [VA_W-1:0]  v_addr;
    logic [FA_W-1:0]  f_addr;
    logic             clr_v_ok;
    logic             clr_f_ok;
    logic             clr_last;
    logic             out_free;
    logic             fail;

    logic             cnt_we;
    logic [VA_W-1:0]  cnt_waddr;
    logic [15:0]      cnt_wdata;
    logic [15:0]      cnt_rdata;
    logic             code_we;
    logic [VA_W-1:0]  code_waddr;
    logic [15:0]      code_wdata;
    logic [15:0]      code_rdata;
    logic             side_we;
    logic [VA_W-1:0]  side_waddr;
    logic [1:0]       side_wdata;
    logic [1:0]       side_rdata;
    logic             face_we;
    logic [FA_W-1:0]  face_waddr;
    logic [2:0]       face_wdata;
    logic [2:0]       face_rdata;

    always_comb
    begin
        case (k_reg)
            2'd0:    v_sel = cmd_reg.vertex_a;
            2'd1:    v_sel = cmd_reg.vertex_b;
            default: v_sel = cmd_reg.vertex_c;
        endcase
    end

    assign v_ext    = 17'(v_sel);
    assign f_ext    = 17'(cmd_reg.face_index);
    assign v_ok     = 32'(v_sel) < MAX_VERTICES;
    assign f_ok     = 32'(cmd_reg.face_index) < MAX_FACES;
    assign v_addr   = v_ext[VA_W-1:0];
    assign f_addr   = f_ext[FA_W-1:0];
    assign clr_v_ok = 32'(clr_reg) < MAX_VERTICES;
    assign clr_f_ok = 32'(clr_reg) < MAX_FACES;
    assign clr_last = 32'(clr_reg) == MAXD - 1;
    assign out_free = !out_valid_reg || !out_stall;
    assign fail     = (comb_reg & inside_mask) != inside_mask;

    assign status.init_busy = (state_reg == BK_CLEAR);

    tcoc_ram #(.WIDTH(16), .DEPTH(MAX_VERTICES)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(v_addr), .rdata(cnt_rdata)
    );

    tcoc_ram #(.WIDTH(16), .DEPTH(MAX_VERTICES)) u_code_ram (
        .clk(clk), .we(code_we), .waddr(code_waddr), .wdata(code_wdata),
        .raddr(v_addr), .rdata(code_rdata)
    );

    tcoc_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_side_ram (
        .clk(clk), .we(side_we), .waddr(side_waddr), .wdata(side_wdata),
        .raddr(v_addr), .rdata(side_rdata)
    );

    tcoc_ram #(.WIDTH(3), .DEPTH(MAX_FACES)) u_face_ram (
        .clk(clk), .we(face_we), .waddr(face_waddr), .wdata(face_wdata),
        .raddr(f_addr), .rdata(face_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = clr_item_reg ? BK_DONE : BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.func)
                        FUNC_CULL:  state_next = q_cmd.hide ? BK_STATUS_WR : BK_CNT_RD;
                        FUNC_CODES: state_next = BK_VCODE;
                        FUNC_TEST:  state_next = BK_FACE_RD;
                        default:    state_next = BK_CLEAR;
                    endcase
                end
            end
            BK_VCODE:     state_next = BK_VCODE_RES;
            BK_VCODE_RES: state_next = BK_DONE;
            BK_FACE_RD:   state_next = BK_FACE_CHK;
            BK_FACE_CHK:
            begin
                if (f_ok && face_rdata[ST_VISIBLE])
                begin
                    state_next = BK_CODE_RD;
                end
                else
                begin
                    state_next = BK_DONE;
                end
            end
            BK_CODE_RD:   state_next = BK_CODE_ACC;
            BK_CODE_ACC:  state_next = (k_reg == 2'd2) ? BK_DECIDE : BK_CODE_RD;
            BK_DECIDE:    state_next = fail ? BK_CNT_RD : BK_STATUS_WR;
            BK_CNT_RD:    state_next = BK_CNT_WR;
            BK_CNT_WR:    state_next = (k_reg == 2'd2) ? BK_STATUS_WR : BK_CNT_RD;
            BK_STATUS_WR: state_next = BK_DONE;
            BK_DONE:      state_next = out_free ? BK_IDLE : BK_DONE;
            default:      state_next = BK_IDLE;
        endcase
    end

    // memory controls
    always_comb
    begin
        q_pop      = (state_reg == BK_IDLE) && q_valid;
        cnt_we     = 1'b0;
        cnt_waddr  = v_addr;
        cnt_wdata  = cnt_rdata;
        code_we    = 1'b0;
        code_waddr = v_addr;
        code_wdata = cmd_reg.vertex_outcodes;
        side_we    = 1'b0;
        side_waddr = v_addr;
        side_wdata = side_rdata | (cmd_reg.reversed ? SIDE_BACK : SIDE_FRONT);
        face_we    = 1'b0;
        face_waddr = f_addr;
        face_wdata = st_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                cnt_we     = clr_v_ok;
                code_we    = clr_v_ok;
                side_we    = clr_v_ok;
                face_we    = clr_f_ok;
                cnt_waddr  = clr_reg[VA_W-1:0];
                code_waddr = clr_reg[VA_W-1:0];
                side_waddr = clr_reg[VA_W-1:0];
                face_waddr = clr_reg[FA_W-1:0];
                cnt_wdata  = '0;
                code_wdata = '0;
                side_wdata = '0;
                face_wdata = '0;
            end
            BK_VCODE:
            begin
                code_we = v_ok;
            end
            BK_CNT_WR:
            begin
                cnt_we  = v_ok;
                side_we = v_ok && (cmd_reg.func == FUNC_CULL) && cmd_reg.mark_sides;
                if (cmd_reg.func == FUNC_CULL)
                begin
                    cnt_wdata = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + 16'd1;
                end
                else
                begin
                    cnt_wdata = (cnt_rdata == 16'd0) ? cnt_rdata : cnt_rdata - 16'd1;
                end
            end
            BK_STATUS_WR:
            begin
                face_we = f_ok;
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_reg       <= '0;
            clr_item_reg  <= 1'b0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (q_pop && (q_cmd.func == FUNC_CLEAR))
            begin
                clr_reg      <= '0;
                clr_item_reg <= 1'b1;
                seen_reg     <= 1'b0;
            end
            if ((state_reg == BK_DECIDE) && !fail && ((comb_reg & outside_mask) != 16'd0))
            begin
                seen_reg <= 1'b1;
            end
            if ((state_reg == BK_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                cmd_reg     <= q_cmd;
                k_reg       <= 2'd0;
                comb_reg    <= '0;
                r_clp_reg   <= 1'b0;
                r_codes_reg <= '0;
                r_cnt_reg   <= '0;
                r_sides_reg <= '0;
                r_vis_reg   <= (q_cmd.func == FUNC_CULL) && !q_cmd.hide;
                r_rev_reg   <= (q_cmd.func == FUNC_CULL) && q_cmd.reversed;
                st_reg      <= q_cmd.hide ? 3'b000 : {1'b0, q_cmd.reversed, 1'b1};
            end
            BK_VCODE_RES:
            begin
                r_cnt_reg   <= v_ok ? cnt_rdata : 16'd0;
                r_sides_reg <= v_ok ? side_rdata : 2'd0;
            end
            BK_FACE_CHK:
            begin
                st_reg <= f_ok ? face_rdata : 3'b000;
            end
            BK_CODE_ACC:
            begin
                comb_reg <= comb_reg | (v_ok ? code_rdata : 16'd0);
                k_reg    <= k_reg + 2'd1;
            end
            BK_DECIDE:
            begin
                k_reg <= 2'd0;
                if (fail)
                begin
                    st_reg <= 3'b000;
                end
                else
                begin
                    r_vis_reg <= 1'b1;
                    r_rev_reg <= st_reg[ST_REVERSED];
                    if ((comb_reg & outside_mask) != 16'd0)
                    begin
                        st_reg[ST_CLIPPED] <= 1'b1;
                        r_clp_reg          <= 1'b1;
                        r_codes_reg        <= comb_reg & outside_mask;
                    end
                end
            end
            BK_CNT_WR:
            begin
                k_reg <= k_reg + 2'd1;
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    out_word_reg <= '{face_visible: r_vis_reg, face_reversed: r_rev_reg,
                                      face_clipped: r_clp_reg, clip_codes: r_codes_reg,
                                      any_clipped: seen_reg, vertex_refcount: r_cnt_reg,
                                      vertex_sides: r_sides_reg};
                end
            end
            BK_CLEAR:
            begin
                r_vis_reg <= 1'b0;
                r_rev_reg <= 1'b0;
            end
            default:
            begin
                st_reg <= st_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

[hw/rtl/triangle_cull_and_outcode_reject.sv]
// front end: products, then sum, each registered, into a 2-word queue, one word a cycle
// unless stalled; back end: set codes writes codes, then reads count and sides; cull
// counts each vertex up, then writes face status (hidden face: status only); test ORs
// a visible face's codes, counts a rejected face's vertices down, writes status; clear
// wipes all stores; the result sits in an output register, so the back end runs on
// to its next result while a word waits; reset: registers zero, then the clearing pass
module triangle_cull_and_outcode_reject
    import tcoc_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_FACES = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_word
);

    logic signed [31:0] eye_x_reg;
    logic signed [31:0] eye_y_reg;
    logic signed [31:0] eye_z_reg;
    logic [1:0]         cull_mode_reg;
    logic               parallel_reg;
    logic [15:0]        inside_mask_reg;
    logic [15:0]        outside_mask_reg;

    back_status_t status;
    logic         q_push;
    logic         q_ready;
    cmd_t         q_in;
    logic         q_pop;
    logic         q_valid;
    cmd_t         q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_x_reg        <= '0;
            eye_y_reg        <= '0;
            eye_z_reg        <= '0;
            cull_mode_reg    <= CULL_NONE;
            parallel_reg     <= 1'b0;
            inside_mask_reg  <= '0;
            outside_mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EYE_X:        eye_x_reg        <= cfg_data;
                REG_EYE_Y:        eye_y_reg        <= cfg_data;
                REG_EYE_Z:        eye_z_reg        <= cfg_data;
                REG_CULL_MODE:    cull_mode_reg    <= cfg_data[1:0];
                REG_PARALLEL:     parallel_reg     <= cfg_data[0];
                REG_INSIDE_MASK:  inside_mask_reg  <= cfg_data[15:0];
                REG_OUTSIDE_MASK: outside_mask_reg <= cfg_data[15:0];
                default:          parallel_reg     <= parallel_reg;
            endcase
        end
    end

    tcoc_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .in_word             (in_word),
        .eye_x               (eye_x_reg),
        .eye_y               (eye_y_reg),
        .eye_z               (eye_z_reg),
        .cull_mode           (cull_mode_reg),
        .parallel_projection (parallel_reg),
        .status              (status),
        .q_ready             (q_ready),
        .q_push              (q_push),
        .q_cmd               (q_in)
    );

    tcoc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    tcoc_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_FACES    (MAX_FACES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_head),
        .q_pop        (q_pop),
        .inside_mask  (inside_mask_reg),
        .outside_mask (outside_mask_reg),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_word     (out_word)
    );

endmodule

[tb/triangle_cull_and_outcode_reject_tb.sv]
`timescale 1ns / 100ps

module triangle_cull_and_outcode_reject_tb;
    import tcoc_pkg::*;

    localparam int NVERT = 1024;
    localparam int NFACE = 4096;
    localparam int WATCHDOG_LIMIT = 40000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_word;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_word;

    triangle_cull_and_outcode_reject uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
        .out_word(out_word)
    );

    // predictor copy of registers and stores
    logic signed [31:0] eye_x_q, eye_y_q, eye_z_q;
    logic [1:0]         mode_q;
    logic               par_q;
    logic [15:0]        in_mask_q, out_mask_q;
    logic [15:0]        vert_count [NVERT];
    logic [15:0]        vert_codes [NVERT];
    logic [1:0]         vert_sides [NVERT];
    logic [2:0]         face_status [NFACE];
    logic               clip_seen;

    out_word_t results_due[$];
    int  mismatches;
    int  idle_cycles;
    bit  gaps_on;
    bit  hold_rx;
    int  hold_len;
    int  rx_gap;

    always #1 clk = ~clk;

    // dot < reference, exact; floor of the 32.32 sum to 16.16 is an arithmetic shift
    function automatic bit faces_away(in_word_t w);
        logic signed [67:0] dot;
        logic signed [67:0] ref_v;
        dot = 68'(64'(w.normal_x) * 64'(eye_x_q)) + 68'(64'(w.normal_y) * 64'(eye_y_q))
            + 68'(64'(w.normal_z) * 64'(eye_z_q));
        dot = dot >>> 16;
        ref_v = par_q ? 68'sd0 : 68'(w.plane_offset);
        return dot < ref_v;
    endfunction

    task automatic clear_stores();
        for (int i = 0; i < NVERT; i++)
        begin
            vert_count[i] = '0;
            vert_codes[i] = '0;
            vert_sides[i] = '0;
        end
        for (int i = 0; i < NFACE; i++)
            face_status[i] = '0;
        clip_seen = 0;
    endtask

    task automatic count_up(logic [9:0] v);
        if (vert_count[v] != COUNT_MAX)
            vert_count[v]++;
    endtask

    task automatic count_down(logic [9:0] v);
        if (vert_count[v] != 0)
            vert_count[v]--;
    endtask

    task automatic predict_word(in_word_t w);
        out_word_t r;
        logic [2:0]  st;
        logic [15:0] comb;
        bit          back;
        logic [1:0]  s;
        r = '0;
        case (w.func)
            FUNC_CULL:
            begin
                back = (mode_q == CULL_ONE || mode_q == CULL_TWO) ? faces_away(w) : 1'b0;
                if (mode_q == CULL_ONE && back)
                    st = '0;
                else
                begin
                    st = '0;
                    st[ST_VISIBLE] = 1'b1;
                    st[ST_REVERSED] = back;
                    count_up(w.vertex_a);
                    count_up(w.vertex_b);
                    count_up(w.vertex_c);
                    if (mode_q == CULL_TWO)
                    begin
                        s = back ? SIDE_BACK : SIDE_FRONT;
                        vert_sides[w.vertex_a] |= s;
                        vert_sides[w.vertex_b] |= s;
                        vert_sides[w.vertex_c] |= s;
                    end
                end
                face_status[w.face_index] = st;
                r.face_visible = st[ST_VISIBLE];
                r.face_reversed = st[ST_REVERSED];
            end
            FUNC_CODES:
            begin
                vert_codes[w.vertex_a] = w.vertex_outcodes;
                r.vertex_refcount = vert_count[w.vertex_a];
                r.vertex_sides = vert_sides[w.vertex_a];
            end
            FUNC_TEST:
            begin
                st = face_status[w.face_index];
                if (st[ST_VISIBLE])
                begin
                    comb = vert_codes[w.vertex_a] | vert_codes[w.vertex_b]
                         | vert_codes[w.vertex_c];
                    if ((comb & in_mask_q) != in_mask_q)
                    begin
                        face_status[w.face_index] = '0;
                        count_down(w.vertex_a);
                        count_down(w.vertex_b);
                        count_down(w.vertex_c);
                    end
                    else
                    begin
                        if ((comb & out_mask_q) != 0)
                        begin
                            st[ST_CLIPPED] = 1'b1;
                            face_status[w.face_index] = st;
                            clip_seen = 1'b1;
                            r.face_clipped = 1'b1;
                            r.clip_codes = comb & out_mask_q;
                        end
                        r.face_visible = 1'b1;
                        r.face_reversed = st[ST_REVERSED];
                    end
                end
            end
            default:
                clear_stores();
        endcase
        r.any_clipped = clip_seen;
        results_due.push_back(r);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        case (idx)
            REG_EYE_X:        eye_x_q = val;
            REG_EYE_Y:        eye_y_q = val;
            REG_EYE_Z:        eye_z_q = val;
            REG_CULL_MODE:    mode_q = val[1:0];
            REG_PARALLEL:     par_q = val[0];
            REG_INSIDE_MASK:  in_mask_q = val[15:0];
            default:          out_mask_q = val[15:0];
        endcase
    endtask

    // called at a falling edge; returns at a falling edge once accepted,
    // with valid still high so the next word can follow at once
    task automatic send_word(in_word_t w);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_word(w);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic in_word_t rand_word(logic [1:0] fn, int vspan, int fspan);
        in_word_t w;
        w.func = fn;
        w.face_index = 12'($urandom_range(0, fspan));
        w.vertex_a = 10'($urandom_range(0, vspan));
        w.vertex_b = 10'($urandom_range(0, vspan));
        w.vertex_c = 10'($urandom_range(0, vspan));
        w.normal_x = $urandom;
        w.normal_y = $urandom;
        w.normal_z = $urandom;
        w.plane_offset = $urandom;
        w.vertex_outcodes = 16'($urandom);
        if ($urandom_range(0, 3) == 0)
        begin
            w.normal_x = $signed(w.normal_x) >>> $urandom_range(0, 31);
            w.plane_offset = $signed(w.plane_offset) >>> $urandom_range(0, 31);
        end
        return w;
    endfunction

    function automatic in_word_t face_word(logic [1:0] fn, int f, int a, int b, int c,
                                           logic [31:0] nx, logic [31:0] off);
        in_word_t w;
        w = '0;
        w.func = fn;
        w.face_index = 12'(f);
        w.vertex_a = 10'(a);
        w.vertex_b = 10'(b);
        w.vertex_c = 10'(c);
        w.normal_x = nx;
        w.plane_offset = off;
        return w;
    endfunction

    function automatic in_word_t code_word(int v, logic [15:0] codes);
        in_word_t w;
        w = '0;
        w.func = FUNC_CODES;
        w.vertex_a = 10'(v);
        w.vertex_outcodes = codes;
        return w;
    endfunction

    task automatic test_directed();
        write_reg(REG_EYE_X, 32'h0001_0000);
        write_reg(REG_EYE_Y, 32'h8000_0000);
        write_reg(REG_EYE_Z, 32'h7FFF_FFFF);
        write_reg(REG_CULL_MODE, 32'(CULL_TWO));
        write_reg(REG_PARALLEL, 32'd0);
        write_reg(REG_INSIDE_MASK, 32'h0000_00F0);
        write_reg(REG_OUTSIDE_MASK, 32'h0000_000F);
        send_word(face_word(FUNC_CULL, 0, 0, 0, 0, 32'h0002_0000, 32'h0001_0000));
        send_word(face_word(FUNC_CULL, 4095, 1023, 1022, 1, 32'hFFFF_0000, 32'h0));
        send_word(face_word(FUNC_CULL, 7, 5, 6, 7, 32'h0001_0000, 32'h0001_0000));
        send_word(code_word(0, 16'hFFFF));
        send_word(code_word(1023, 16'h00F1));
        send_word(code_word(1022, 16'h00F0));
        send_word(code_word(1, 16'h0000));
        send_word(face_word(FUNC_TEST, 0, 0, 0, 0, 32'h0, 32'h0));
        send_word(face_word(FUNC_TEST, 4095, 1023, 1022, 1, 32'h0, 32'h0));
        send_word(face_word(FUNC_TEST, 7, 5, 6, 7, 32'h0, 32'h0));
        send_word(face_word(FUNC_TEST, 100, 5, 6, 7, 32'h0, 32'h0));
        send_word(code_word(1023, 16'h0));
        send_word(code_word(5, 16'h0));
        send_word({FUNC_CLEAR, {($bits(in_word_t)-2){1'b1}}});
        send_word(code_word(0, 16'h0));
        send_word(face_word(FUNC_TEST, 0, 0, 0, 0, 32'h0, 32'h0));
        drain();
        write_reg(REG_CULL_MODE, 32'd3);
        send_word(face_word(FUNC_CULL, 1, 2, 3, 4, 32'h8000_0000, 32'h7FFF_FFFF));
        drain();
        write_reg(REG_CULL_MODE, 32'(CULL_ONE));
        send_word(face_word(FUNC_CULL, 2, 2, 3, 4, 32'h8000_0000, 32'h7FFF_FFFF));
        send_word(face_word(FUNC_TEST, 2, 2, 3, 4, 32'h0, 32'h0));
        drain();
    endtask

    // well-formed sequences: cull faces, set codes, test them, with some noise
    task automatic test_random(int count, int vspan, int fspan);
        in_word_t w;
        int n;
        n = 0;
        while (n < count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: w = rand_word(FUNC_CULL, vspan, fspan);
                4, 5:       w = rand_word(FUNC_CODES, vspan, fspan);
                6, 7, 8:    w = rand_word(FUNC_TEST, vspan, fspan);
                default:    w = ($urandom_range(0, 40) == 0) ?
                                rand_word(FUNC_CLEAR, vspan, fspan) :
                                rand_word(FUNC_CULL, 1023, 4095);
            endcase
            if (w.func == FUNC_CODES && $urandom_range(0, 2) == 0)
                w.vertex_outcodes = w.vertex_outcodes & ~in_mask_q;
            else if (w.func == FUNC_CODES)
                w.vertex_outcodes = w.vertex_outcodes | in_mask_q;
            send_word(w);
            n++;
        end
        drain();
    endtask

    task automatic test_settings();
        logic [31:0] eyes [4];
        eyes = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_EYE_X, (p < 4) ? eyes[p] : $urandom);
            write_reg(REG_EYE_Y, (p < 4) ? eyes[3-p] : $urandom);
            write_reg(REG_EYE_Z, $urandom);
            write_reg(REG_CULL_MODE, 32'(p % 4));
            write_reg(REG_PARALLEL, 32'(p[0] ^ p[2]));
            write_reg(REG_INSIDE_MASK, (p == 0) ? 32'h0 : (p == 1) ? 32'hFFFF : $urandom);
            write_reg(REG_OUTSIDE_MASK, (p == 2) ? 32'h0 : (p == 3) ? 32'hFFFF : $urandom);
            test_random(180, (p < 6) ? 31 : 1023, (p < 6) ? 31 : 4095);
        end
    endtask

    task automatic test_backpressure();
        hold_len = 300;
        hold_rx = 1;
        test_random(60, 15, 15);
    endtask

    task automatic test_no_gaps();
        gaps_on = 0;
        test_random(150, 31, 31);
    endtask

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 0;
            rx_gap <= 0;
        end
        else if (hold_rx && hold_len > 0)
        begin
            out_stall <= 1;
            hold_len <= hold_len - 1;
            if (hold_len == 1)
                hold_rx <= 0;
        end
        else if (rx_gap > 0)
        begin
            out_stall <= 1;
            rx_gap <= rx_gap - 1;
        end
        else if (gaps_on && $urandom_range(0, 6) == 0)
        begin
            out_stall <= 1;
            rx_gap <= $urandom_range(0, 3);
        end
        else
            out_stall <= 0;
    end

    // checker and watchdog
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no words moving", $time);
                $display("FAILED: results differ");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t unexpected word: expected none, actual %h", $time, out_word);
                    mismatches++;
                end
                else
                begin
                    e = results_due.pop_front();
                    if (out_word !== e)
                    begin
                        $display("%0t mismatch: expected %h, actual %h", $time, e, out_word);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        in_word = '0;
        out_stall = 0;
        mismatches = 0;
        idle_cycles = 0;
        gaps_on = 1;
        hold_rx = 0;
        hold_len = 0;
        rx_gap = 0;
        eye_x_q = 0;
        eye_y_q = 0;
        eye_z_q = 0;
        mode_q = CULL_NONE;
        par_q = 0;
        in_mask_q = 0;
        out_mask_q = 0;
        clear_stores();
        repeat (7) @(negedge clk);
        rst_n = 1;
        test_directed();
        test_settings();
        test_backpressure();
        test_no_gaps();
        $display("covered all funcs and cull modes over eight register settings,");
        $display("a long output hold-off and a final stretch without idling");
        if (mismatches == 0 && results_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/tcoc_pkg.sv
hw/rtl/tcoc_ram.sv
hw/rtl/tcoc_front.sv
hw/rtl/tcoc_queue.sv
hw/rtl/tcoc_back.sv
hw/rtl/triangle_cull_and_outcode_reject.sv
tb/triangle_cull_and_outcode_reject_tb.sv
